@@ hdl/selective_repeat_receive_window_top_macros.svh @@
// Assertion macros shared by the receive window RTL.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRRW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/srrw_pkg.sv @@
// Shared types and constants of the selective-repeat receive window.
package srrw_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SEQ_W      = 32;
    localparam int HELD_W     = 16;

    typedef enum logic {
        ALU_SUB,
        ALU_INC
    } t_alu_op;

    localparam logic KIND_SACK   = 1'b0;
    localparam logic KIND_FINACK = 1'b1;

endpackage

@@ hdl/selective_repeat_receive_window_top.sv @@
// Selective-repeat receive window: one segment header in, at most one SACK or FIN-ACK out.
// Each accepted item is captured and then evaluated against the window. For a newly held
// frame, the window next slides over the contiguous held frames at its start (0 to WINDOW),
// one step per frame, until it finds the end of that run. The reply is then handed to the
// output register. A single 32-bit add/subtract unit is reused for the window compare, the FIN
// sequence increment and each step of the cumulative ack; the hand-over waits while an earlier
// reply still sits unread. Corrupt segments and segments after FIN are taken with no reply, and
// a segment beyond the window is dropped after its evaluation, also with no reply. The output
// register lets the next item be accepted while a reply still waits.
// Writing first_seq starts a new session; write it only while the block is idle.
`include "selective_repeat_receive_window_top_macros.svh"

module selective_repeat_receive_window_top #(
    parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,     // first_seq
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,       // [31:0] seq_num
    input  logic [1:0]  i_s_tuser,       // [0] is_fin, [1] checksum_ok
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,       // [31:0] ack_value, [47:32] held_marks
    output logic        o_m_tuser        // [0] reply_kind
);

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW = srrw_pkg::SEQ_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                r_state,    n_state;
    logic [SW-1:0]             r_last,     n_last;
    logic [WINDOW-1:0]         r_marks,    n_marks;
    logic                      r_finished, n_finished;
    logic [SW-1:0]             r_seq,      n_seq;
    logic                      r_fin,      n_fin;
    logic [SW-1:0]             r_fin_ack,  n_fin_ack;
    logic                      r_o_valid,  n_o_valid;
    logic                      r_o_kind,   n_o_kind;
    logic [SW-1:0]             r_o_ack,    n_o_ack;
    logic [srrw_pkg::HELD_W-1:0] r_o_held, n_o_held;

    srrw_pkg::t_alu_op w_op;
    logic [SW-1:0]     w_a;
    logic [SW-1:0]     w_sum;
    logic              w_carry;
    logic [PW-1:0]     w_pos;

    always_comb begin
        if (r_state == ST_EVAL && !r_fin) begin
            w_op = srrw_pkg::ALU_SUB;
            w_a  = r_seq;
        end else if (r_state == ST_EVAL) begin
            w_op = srrw_pkg::ALU_INC;
            w_a  = r_seq;
        end else begin
            w_op = srrw_pkg::ALU_INC;
            w_a  = r_last;
        end
    end

    srrw_addsub u_alu (
        .i_a     (w_a),
        .i_b     (r_last),
        .i_op    (w_op),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    // Offset of the frame in the window: distance minus one, known to be below WINDOW.
    assign w_pos = PW'(w_sum[PW:0] - (PW+1)'(1));

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        n_marks    = r_marks;
        n_finished = r_finished;
        n_seq      = r_seq;
        n_fin      = r_fin;
        n_fin_ack  = r_fin_ack;
        n_o_valid  = r_o_valid;
        n_o_kind   = r_o_kind;
        n_o_ack    = r_o_ack;
        n_o_held   = r_o_held;

        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                // Drop corrupt items and everything after FIN.
                if (i_s_tvalid && i_s_tuser[1] && !r_finished) begin
                    n_seq   = i_s_tdata;
                    n_fin   = i_s_tuser[0];
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_fin) begin
                    n_fin_ack  = w_sum;
                    n_finished = 1'b1;
                    n_state    = ST_EMIT;
                end else if (!w_carry || w_sum == '0) begin
                    n_state = ST_EMIT;
                end else if (w_sum > SW'(WINDOW)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_marks = r_marks | (WINDOW'(1) << w_pos);
                    n_state = ST_ADV;
                end
            end
            ST_ADV: begin
                if (r_marks[0]) begin
                    n_marks = r_marks >> 1;
                    n_last  = w_sum;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_fin ? srrw_pkg::KIND_FINACK : srrw_pkg::KIND_SACK;
                    n_o_ack   = r_fin ? r_fin_ack : r_last;
                    n_o_held  = r_fin ? '0 : srrw_pkg::HELD_W'(r_marks);
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A first_seq write opens a new session.
        if (i_cfg_we) begin
            n_last     = i_cfg_wdata - 32'd1;
            n_marks    = '0;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_last     <= '1;
            r_marks    <= '0;
            r_finished <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_last     <= n_last;
            r_marks    <= n_marks;
            r_finished <= n_finished;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_fin     <= n_fin;
        r_fin_ack <= n_fin_ack;
        r_o_kind  <= n_o_kind;
        r_o_ack   <= n_o_ack;
        r_o_held  <= n_o_held;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_held, r_o_ack};
    assign o_m_tuser  = r_o_kind;

    `SRRW_ASSERT_NEXT(a_adv_step, i_clk, i_rst_n, (r_state == ST_ADV && r_marks[0] && !i_cfg_we), (r_last == SW'($past(r_last) + 32'd1)), "slide step did not advance the cumulative ack by one")
    `SRRW_ASSERT_NOW(a_marks_settled, i_clk, i_rst_n, (r_state == ST_IDLE || r_state == ST_EMIT), (!r_marks[0]), "frame after cumulative ack left marked outside the slide loop")
    `SRRW_ASSERT_NEXT(a_adv_exit, i_clk, i_rst_n, (r_state == ST_ADV && !r_marks[0] && !i_cfg_we), (r_state == ST_EMIT), "slide loop did not hand over to reply stage")
    `SRRW_ASSERT_NEXT(a_fin_latch, i_clk, i_rst_n, (r_state == ST_EVAL && r_fin && !i_cfg_we), (r_finished && r_state == ST_EMIT), "FIN segment did not close the session")

endmodule

@@ hdl/srrw_addsub.sv @@
// Shared 32-bit add/subtract unit: a - b with carry, or a + 1.
module srrw_addsub (
    input  logic [srrw_pkg::SEQ_W-1:0] i_a,
    input  logic [srrw_pkg::SEQ_W-1:0] i_b,
    input  srrw_pkg::t_alu_op          i_op,
    output logic [srrw_pkg::SEQ_W-1:0] o_sum,
    output logic                       o_carry
);

    logic [srrw_pkg::SEQ_W:0]   w_full;
    logic [srrw_pkg::SEQ_W-1:0] w_b;

    always_comb begin
        case (i_op)
            srrw_pkg::ALU_SUB: w_b = ~i_b;
            srrw_pkg::ALU_INC: w_b = '0;
            default:           w_b = '0;
        endcase
    end

    // Carry-in of one serves both the two's complement and the increment.
    assign w_full  = {1'b0, i_a} + {1'b0, w_b} + {{srrw_pkg::SEQ_W{1'b0}}, 1'b1};
    assign o_sum   = w_full[srrw_pkg::SEQ_W-1:0];
    assign o_carry = w_full[srrw_pkg::SEQ_W];

endmodule
